// ----- hw/rtl/falru_pkg.sv -----
// ----------------------------------------------------------------------------
// falru_pkg
// Shared constants and types for the fully associative LRU tag store.
// ----------------------------------------------------------------------------
package falru_pkg;

  localparam int MaxEntries = 16;
  localparam int AddrW      = 32;
  localparam int CntW       = 32;
  localparam int CfgW       = 5;
  localparam int FillW      = $clog2(MaxEntries + 1);
  localparam int CapW       = (FillW > CfgW) ? FillW : CfgW;

  localparam logic [CfgW-1:0] CfgReset = CfgW'(16);

  typedef struct packed {
    logic             hit;
    logic             evict;
    logic [AddrW-1:0] victim;
  } falru_lookup_t;

endpackage

// ----- hw/rtl/falru_tag_store.sv -----
// ----------------------------------------------------------------------------
// falru_tag_store
// Tag registers kept in recency order, least recent at position zero, with
// parallel compare and a registered reorder on every processed word.
// ----------------------------------------------------------------------------
module falru_tag_store
  import falru_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                upd_i,
  input  logic [AddrW-1:0]    addr_i,
  input  logic [CfgW-1:0]     cfg_i,
  output falru_lookup_t       lookup_o
);

  logic [AddrW-1:0] tag_q [MaxEntries];
  logic [AddrW-1:0] tag_d [MaxEntries];
  logic [FillW-1:0] filled_q, filled_d;

  logic [MaxEntries-1:0] match;
  logic [FillW-1:0]      pos;
  logic [CapW-1:0]       cap;
  logic                  room;
  logic                  shifting;
  logic [FillW-1:0]      shift_from;
  logic [FillW-1:0]      last;

  always_comb begin
    if (cfg_i == '0) begin
      cap = CapW'(1);
    end else if (CapW'(cfg_i) > CapW'(MaxEntries)) begin
      cap = CapW'(MaxEntries);
    end else begin
      cap = CapW'(cfg_i);
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      match[i] = (FillW'(i) < filled_q) && (tag_q[i] == addr_i);
      if (match[i]) begin
        pos = pos | FillW'(i);
      end
    end
  end

  assign room           = !(|match) && (CapW'(filled_q) < cap);
  assign shifting       = !room;
  assign shift_from     = (|match) ? pos : '0;
  assign last           = room ? filled_q : filled_q - FillW'(1);

  assign lookup_o.hit    = |match;
  assign lookup_o.evict  = !(|match) && !room;
  assign lookup_o.victim = lookup_o.evict ? tag_q[0] : '0;

  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      tag_d[i] = tag_q[i];
      if (FillW'(i) == last) begin
        tag_d[i] = addr_i;
      end else if (shifting && FillW'(i) >= shift_from && FillW'(i) < last &&
                   i < MaxEntries - 1) begin
        tag_d[i] = tag_q[(i + 1) % MaxEntries];
      end
    end
    filled_d = room ? filled_q + FillW'(1) : filled_q;
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      for (int i = 0; i < MaxEntries; i++) begin
        tag_q[i] <= tag_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else if (upd_i) begin
      filled_q <= filled_d;
    end
  end

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && lookup_o.hit |-> !lookup_o.evict)
    else $error("hit and eviction flagged together");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= FillW'(MaxEntries))
    else $error("fill level above entry count");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && !lookup_o.hit && !lookup_o.evict |=> filled_q == $past(filled_q) + FillW'(1))
    else $error("miss with room did not add an entry");

  a_evict_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && lookup_o.evict |-> filled_q != '0)
    else $error("eviction from an empty store");

endmodule

// ----- hw/rtl/falru_stats.sv -----
// ----------------------------------------------------------------------------
// falru_stats
// Saturating hit, miss and eviction counters.
// ----------------------------------------------------------------------------
module falru_stats
  import falru_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            upd_i,
  input  falru_lookup_t   lookup_i,
  output logic [CntW-1:0] hits_o,
  output logic [CntW-1:0] misses_o,
  output logic [CntW-1:0] evictions_o
);

  logic [CntW-1:0] hits_q, hits_d;
  logic [CntW-1:0] misses_q, misses_d;
  logic [CntW-1:0] evict_q, evict_d;

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    evict_d  = evict_q;
    if (lookup_i.hit) begin
      if (hits_q != '1) begin
        hits_d = hits_q + CntW'(1);
      end
    end else if (misses_q != '1) begin
      misses_d = misses_q + CntW'(1);
    end
    if (lookup_i.evict && evict_q != '1) begin
      evict_d = evict_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evict_q  <= '0;
    end else if (upd_i) begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evict_q  <= evict_d;
    end
  end

  assign hits_o      = hits_q;
  assign misses_o    = misses_q;
  assign evictions_o = evict_q;

  a_evict_le_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && lookup_i.evict |-> !lookup_i.hit)
    else $error("eviction counted on a hit");

  a_one_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && misses_q != '1 && hits_q != '1 |=>
      (hits_q - $past(hits_q)) + (misses_q - $past(misses_q)) == CntW'(1))
    else $error("processed word did not bump exactly one of hit and miss");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !upd_i |=> $stable(hits_q) && $stable(misses_q) && $stable(evict_q))
    else $error("counter moved without a processed word");

endmodule

// ----- hw/rtl/fully_associative_lru_cache_top.sv -----
// ----------------------------------------------------------------------------
// fully_associative_lru_cache_top
// Fully associative tag store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each word on the input channel (in_valid_i / in_ready_o) carries one
// address. Each word on the output channel (out_valid_o / out_ready_i)
// reports hit, eviction and the evicted address, plus saturating totals.
// A word is registered on acceptance, compared against all held tags and
// reordered once the result register is free, and its result is registered.
// One word per cycle is sustained while results are taken, as the parallel
// tag compare and recency shift are combinational. When the receiver stalls,
// the result register holds, the input register fills, and in_ready_o drops
// until the result is taken. Capacity is written through cfg_we_i /
// cfg_wdata_i by the user only while idle; the block does not enforce it.
// Reset empties the store, clears the totals and sets capacity to 16.
// ----------------------------------------------------------------------------
module fully_associative_lru_cache_top
  import falru_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [AddrW-1:0] access_address_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             was_hit_o,
  output logic             did_evict_o,
  output logic [AddrW-1:0] evicted_address_o,
  output logic [CntW-1:0]  hits_total_o,
  output logic [CntW-1:0]  misses_total_o,
  output logic [CntW-1:0]  evictions_total_o
);

  logic [CfgW-1:0]  cap_q;
  logic             in_valid_q;
  logic [AddrW-1:0] addr_q;
  logic             out_valid_q;
  logic             hit_q;
  logic             evict_q;
  logic [AddrW-1:0] victim_q;
  logic             out_free;
  logic             proc;
  falru_lookup_t    lookup;

  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CfgReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      addr_q <= access_address_i;
    end
    if (proc) begin
      hit_q    <= lookup.hit;
      evict_q  <= lookup.evict;
      victim_q <= lookup.victim;
    end
  end

  falru_tag_store u_tags (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (proc),
    .addr_i   (addr_q),
    .cfg_i    (cap_q),
    .lookup_o (lookup)
  );

  falru_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (proc),
    .lookup_i    (lookup),
    .hits_o      (hits_total_o),
    .misses_o    (misses_total_o),
    .evictions_o (evictions_total_o)
  );

  assign out_valid_o       = out_valid_q;
  assign was_hit_o         = hit_q;
  assign did_evict_o       = evict_q;
  assign evicted_address_o = victim_q;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=>
      out_valid_q && $stable(hit_q) && $stable(evict_q) && $stable(victim_q))
    else $error("stalled result overwritten");

  a_proc_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> out_valid_q)
    else $error("processed word produced no result");

  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while both stages are full and stalled");

endmodule
